// File: sv/dnp3_link_header_checker_defines.svh
// Assertion macros for the DNP3 link header checker's port-level assertions.
`ifndef DNP3_LINK_HEADER_CHECKER_DEFINES_SVH
`define DNP3_LINK_HEADER_CHECKER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define DLHC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dnp3 link header checker assertion failed");

// Property that also holds across reset.
`define DLHC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dnp3 link header checker reset assertion failed");

`endif

// File: sv/dnp3lhc_pkg.sv
// Types and constants of the DNP3 link header checker.
package dnp3lhc_pkg;

  localparam logic [7:0]  START_BYTE0     = 8'h05;
  localparam logic [7:0]  START_BYTE1     = 8'h64;
  localparam logic [7:0]  MIN_LENGTH      = 8'd5;
  localparam logic [15:0] CRC_POLY_REFL   = 16'hA6BC;
  localparam logic [15:0] BROADCAST_ADDR  = 16'hFFFF;

  // Header byte positions; POS_IDLE means no header is being collected.
  typedef enum logic [3:0] {
    POS_START0 = 4'd0,
    POS_START1 = 4'd1,
    POS_LENGTH = 4'd2,
    POS_CTRL   = 4'd3,
    POS_DST_LO = 4'd4,
    POS_DST_HI = 4'd5,
    POS_SRC_LO = 4'd6,
    POS_SRC_HI = 4'd7,
    POS_CRC_LO = 4'd8,
    POS_CRC_HI = 4'd9,
    POS_IDLE   = 4'd10
  } byte_pos_t;

  typedef struct packed {
    logic        header_ok;
    logic        crc_ok;
    logic [7:0]  frame_length;
    logic        direction_bit;
    logic        primary_bit;
    logic        fcb_bit;
    logic        dfc_bit;
    logic [3:0]  link_function;
    logic [15:0] destination_address;
    logic [15:0] source_address;
    logic        broadcast;
  } result_t;

endpackage

// File: sv/dnp3_link_header_checker.sv
// Top level of the DNP3 link header checker.
// Usage: frame bytes enter one per request on the input channel (in_valid,
// in_stall, data_byte, frame_start); frame_start marks byte 0 of a frame.
// After byte 9 of a ten-byte link header the block offers one result request
// on the output channel (out_valid, out_stall) carrying the decoded header
// fields, the start/length check and the CRC-16/DNP check.
// Bytes before the first frame start and after byte 9 give no result.
// A frame start in the middle of a header discards the partial header.
// Throughput is one byte per cycle while the receiver does not stall; each byte
// is held in the input register and then applied to the header state, which is
// one byte-wide CRC update and a field capture.
// Byte 9 passes the input register, then its result lands in the result register.
// While the receiver stalls, the result register holds its request and the
// input register can still take one more byte; further input is stalled.
// Synchronous reset empties both registers and returns to waiting for a
// frame start.
module dnp3_link_header_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        header_ok,
  output logic        crc_ok,
  output logic [7:0]  frame_length,
  output logic        direction_bit,
  output logic        primary_bit,
  output logic        fcb_bit,
  output logic        dfc_bit,
  output logic [3:0]  link_function,
  output logic [15:0] destination_address,
  output logic [15:0] source_address,
  output logic        broadcast
);
  import dnp3lhc_pkg::*;

  logic       in_reg_valid;
  logic [7:0] in_reg_data;
  logic       in_reg_start;
  logic       advance;
  logic       emit;
  result_t    result;
  result_t    out_reg;

  // The staged byte moves on whenever the result register can take a result.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_data  <= data_byte;
      in_reg_start <= frame_start;
    end
  end

  dnp3lhc_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (in_reg_valid && advance),
    .data   (in_reg_data),
    .start  (in_reg_start),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= result;
    end
  end

  assign header_ok           = out_reg.header_ok;
  assign crc_ok              = out_reg.crc_ok;
  assign frame_length        = out_reg.frame_length;
  assign direction_bit       = out_reg.direction_bit;
  assign primary_bit         = out_reg.primary_bit;
  assign fcb_bit             = out_reg.fcb_bit;
  assign dfc_bit             = out_reg.dfc_bit;
  assign link_function       = out_reg.link_function;
  assign destination_address = out_reg.destination_address;
  assign source_address      = out_reg.source_address;
  assign broadcast           = out_reg.broadcast;

endmodule

// File: sv/dnp3lhc_crc.sv
// One-byte update of the reflected CRC-16/DNP.
module dnp3lhc_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import dnp3lhc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: sv/dnp3lhc_parse.sv
// Header field capture and result formation, one byte per step.
module dnp3lhc_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data,
  input  logic                start,
  output logic                emit,
  output dnp3lhc_pkg::result_t result
);
  import dnp3lhc_pkg::*;

  byte_pos_t   pos, pos_next, cur_pos;
  logic [15:0] crc, crc_base, crc_upd;
  logic        start_ok;
  logic [7:0]  length_hold;
  logic [7:0]  control_hold;
  logic [15:0] destination_hold;
  logic [15:0] source_hold;
  logic [7:0]  crc_low;
  logic [15:0] crc_rx;

  // A frame start restarts the header no matter where the previous one stood.
  assign cur_pos  = start ? POS_START0 : pos;
  assign crc_base = start ? 16'h0000 : crc;

  dnp3lhc_crc u_crc (
    .crc_in  (crc_base),
    .data    (data),
    .crc_out (crc_upd)
  );

  always_comb begin
    unique case (cur_pos)
      POS_START0: pos_next = POS_START1;
      POS_START1: pos_next = POS_LENGTH;
      POS_LENGTH: pos_next = POS_CTRL;
      POS_CTRL:   pos_next = POS_DST_LO;
      POS_DST_LO: pos_next = POS_DST_HI;
      POS_DST_HI: pos_next = POS_SRC_LO;
      POS_SRC_LO: pos_next = POS_SRC_HI;
      POS_SRC_HI: pos_next = POS_CRC_LO;
      POS_CRC_LO: pos_next = POS_CRC_HI;
      default:    pos_next = POS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= POS_IDLE;
      crc              <= '0;
      start_ok         <= 1'b0;
      length_hold      <= '0;
      control_hold     <= '0;
      destination_hold <= '0;
      source_hold      <= '0;
      crc_low          <= '0;
    end else if (step && (cur_pos != POS_IDLE)) begin
      pos <= pos_next;
      if (cur_pos < POS_CRC_LO) begin
        crc <= crc_upd;
      end else begin
        crc <= crc_base;
      end
      case (cur_pos)
        POS_START0: start_ok <= (data == START_BYTE0);
        POS_START1: start_ok <= start_ok && (data == START_BYTE1);
        POS_LENGTH: length_hold <= data;
        POS_CTRL:   control_hold <= data;
        POS_DST_LO: destination_hold <= {8'h00, data};
        POS_DST_HI: destination_hold <= {data, destination_hold[7:0]};
        POS_SRC_LO: source_hold <= {8'h00, data};
        POS_SRC_HI: source_hold <= {data, source_hold[7:0]};
        POS_CRC_LO: crc_low <= data;
        default: ;
      endcase
    end
  end

  assign emit   = step && (cur_pos == POS_CRC_HI);
  assign crc_rx = {data, crc_low};

  always_comb begin
    result.header_ok           = start_ok && (length_hold >= MIN_LENGTH);
    result.crc_ok              = (crc_rx == ~crc);
    result.frame_length        = length_hold;
    result.direction_bit       = control_hold[7];
    result.primary_bit         = control_hold[6];
    result.fcb_bit             = control_hold[5];
    result.dfc_bit             = control_hold[4];
    result.link_function       = control_hold[3:0];
    result.destination_address = destination_hold;
    result.source_address      = source_hold;
    result.broadcast           = (destination_hold == BROADCAST_ADDR);
  end

endmodule

// File: sv/dnp3lhc_checker.sv
// Port-level assertions for the DNP3 link header checker and their binding.
`include "dnp3_link_header_checker_defines.svh"

module dnp3lhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        header_ok,
  input logic [7:0]  frame_length,
  input logic [15:0] destination_address,
  input logic        broadcast
);
  import dnp3lhc_pkg::*;

  // A result held under stall keeps its request, destination address and frame length.
  `DLHC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(destination_address) && $stable(frame_length))
  // The broadcast flag follows the destination address.
  `DLHC_ASSERT(a_broadcast, clk, rst, out_valid |-> (broadcast == (destination_address == BROADCAST_ADDR)))
  // A good header never carries a short length.
  `DLHC_ASSERT(a_len_ok, clk, rst, out_valid && header_ok |-> frame_length >= MIN_LENGTH)
  // The input side only stalls while a result waits on a stalled receiver.
  `DLHC_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)
  // Reset leaves no result pending.
  `DLHC_ASSERT_RST(a_reset, clk, rst |=> !out_valid)

endmodule

bind dnp3_link_header_checker dnp3lhc_checker u_dnp3lhc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .header_ok           (header_ok),
  .frame_length        (frame_length),
  .destination_address (destination_address),
  .broadcast           (broadcast)
);
